// ----- design/otwo_pkg.sv -----
// shared constants and types of the three-wheel omni odometry block
package otwo_pkg;

	// cordic iteration count and the width of its step counter
	localparam int CORDIC_STEPS = 16;
	localparam int ITER_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	// port widths
	localparam int CNT_W  = 32;
	localparam int POS_W  = 32;
	localparam int HDG_W  = 25;
	localparam int GAIN_W = 32;
	localparam int FL_W   = 16;
	localparam int IN_W   = 144;
	localparam int OUT_W  = 192;
	localparam int CIDX_W = 2;

	// heading limits in q9.16 degrees
	localparam logic signed [HDG_W-1:0] DEG180 = 25'sd11796480;
	localparam logic signed [HDG_W-1:0] DEG90  = 25'sd5898240;

	localparam logic [FL_W-1:0] FIELD_LENGTH_RST = 16'd3000;

	typedef enum logic [CIDX_W-1:0] {
		CFG_HEADING_GAIN = 2'd0,
		CFG_LINEAR_GAIN  = 2'd1,
		CFG_FIELD_LENGTH = 2'd2
	} cfg_idx_t;

	// arctangent steps in q24 degrees
	typedef logic [31:0] atan_tab_t [CORDIC_STEPS];

	function automatic atan_tab_t atan_table();
		atan_tab_t t;
		longint    v;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			case (i)
				0:  v = 754974720;
				1:  v = 445687602;
				2:  v = 235489088;
				3:  v = 119537938;
				4:  v = 60000934;
				5:  v = 30029717;
				6:  v = 15018523;
				7:  v = 7509720;
				8:  v = 3754917;
				9:  v = 1877466;
				10: v = 938734;
				11: v = 469367;
				default: v = (64'sd961263669 + (64'sd1 <<< (i - 1))) >>> i;
			endcase
			t[i] = v[31:0];
		end
		return t;
	endfunction

	localparam atan_tab_t ATAN_TAB = atan_table();

endpackage

// ----- design/omni_three_wheel_odometry.sv -----
// dead-reckoning odometry for a three-wheel omni base, digit-serial datapath
//
// input channel s_axis: one item per odometry tick (tuser = 0) or per set-pose
// command (tuser = 1). a tick carries the three wheel step counters; the block
// takes wrapping deltas against the latched counters, rotates the wheel matrix
// by the old heading (cordic), scales and accumulates x, y and heading.
// a set-pose item loads the pose (optionally mirrored about field_length with
// the heading negated) and latches the counters; its deltas read zero.
// output channel m_axis: one item per input item with pose and deltas.
// config port: cfg_we / cfg_index / cfg_data; the user writes it only while idle, the block does not enforce it.
//
// a tick runs the cordic, then the bit-serial matrix sum, the bit-serial gain multiply
// and the bit-serial divide by three before m_axis_tvalid rises; a set-pose item
// goes from accept straight to the output state and skips the serial datapath.
// one item is in flight at a time; s_axis_tready is high only when idle.
// the finished item sits in the output register, so the next item is taken
// while m_axis waits; if the receiver still stalls when the next result is
// ready, the block holds that result in its final state until the slot frees.
// reset clears the pose, the latched counters and the gains, field_length = 3000
module omni_three_wheel_odometry (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// wheel_count_a, wheel_count_b, wheel_count_c, new_x_mm, new_y_mm,
	// new_heading_deg, mirror, zero fill
	input  logic [otwo_pkg::IN_W-1:0]     s_axis_tdata,
	// mode
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// pos_x, pos_y, heading, delta_a, delta_b, delta_c, zero fill
	output logic [otwo_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                          cfg_we,
	input  logic [otwo_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [otwo_pkg::GAIN_W-1:0]   cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_TRIG, ST_ROUND, ST_ROOT3, ST_COEF, ST_MAT,
		ST_ABS, ST_MUL, ST_PREP, ST_DIV, ST_SUM, ST_OUT
	} state_t;

	localparam logic signed [25:0] H180  = 26'sd11796480;
	localparam logic signed [25:0] H360  = 26'sd23592960;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
	localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;
	localparam logic signed [37:0] SAT_MAX = 38'sd2147483647;
	localparam logic signed [37:0] SAT_MIN = -38'sd2147483648;
	localparam int ITER_LAST_W = otwo_pkg::ITER_W;
	localparam logic [ITER_LAST_W-1:0] ITER_LAST = ITER_LAST_W'(otwo_pkg::CORDIC_STEPS - 1);

	function automatic logic signed [24:0] wrap_hdg(input logic signed [25:0] h);
		logic signed [25:0] w;
		w = h;
		if (h > H180) begin
			w = h - H360;
		end else if (h < -H180) begin
			w = h + H360;
		end
		return w[24:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		logic signed [31:0] r;
		r = v[31:0];
		if (v > SAT_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_MIN) begin
			r = 32'sh80000000;
		end
		return r;
	endfunction

	// input fields
	logic signed [31:0] in_cnt_a, in_cnt_b, in_cnt_c;
	logic signed [15:0] in_new_x, in_new_y;
	logic signed [8:0]  in_new_hdg;
	logic               in_mirror;

	assign in_cnt_a   = s_axis_tdata[31:0];
	assign in_cnt_b   = s_axis_tdata[63:32];
	assign in_cnt_c   = s_axis_tdata[95:64];
	assign in_new_x   = s_axis_tdata[111:96];
	assign in_new_y   = s_axis_tdata[127:112];
	assign in_new_hdg = s_axis_tdata[136:128];
	assign in_mirror  = s_axis_tdata[137];

	// control and architectural state
	state_t                          state_q;
	logic [ITER_LAST_W-1:0]          iter_q;
	logic [5:0]                      bit_q;
	logic                            out_valid_q;
	logic [otwo_pkg::OUT_W-1:0]      out_data_q;
	logic [31:0]                     heading_gain_q, linear_gain_q;
	logic [15:0]                     field_length_q;
	logic signed [31:0]              x_acc_q, y_acc_q;
	logic signed [24:0]              heading_acc_q;
	logic [31:0]                     last_a_q, last_b_q, last_c_q;

	// working registers
	logic signed [31:0] da_q, db_q, dc_q;
	logic [31:0]        da_sh_q, db_sh_q, dc_sh_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               fold_neg_q;
	logic signed [19:0] cos_q, sin_q, r3s_q, r3c_q;
	logic signed [33:0] sumd_q;
	logic signed [20:0] kxa_q, kxb_q, kxc_q, kya_q, kyb_q, kyc_q;
	logic signed [53:0] tx_q, ty_q;
	logic [53:0]        magx_q, magy_q;
	logic [32:0]        magh_q;
	logic               sgnx_q, sgny_q, sgnh_q;
	logic [31:0]        lg_sh_q, hg_sh_q;
	logic [85:0]        px_q, py_q;
	logic [64:0]        ph_q;
	logic [35:0]        dvx_q, dvy_q;
	logic [1:0]         remx_q, remy_q;
	logic signed [31:0] nx_q, ny_q;
	logic signed [24:0] nh_q;

	logic in_take;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// set pose
	logic signed [17:0] sp_x18;
	logic signed [31:0] sp_x;
	logic signed [9:0]  sp_h10;
	logic signed [24:0] sp_h;

	always_comb begin
		sp_x18 = in_mirror ? ($signed({2'b00, field_length_q}) - 18'(in_new_x))
			: 18'(in_new_x);
		if (sp_x18 > 18'sd32767) begin
			sp_x = 32'sh7FFFFFFF;
		end else if (sp_x18 < -18'sd32768) begin
			sp_x = 32'sh80000000;
		end else begin
			sp_x = {sp_x18[15:0], 16'h0000};
		end
		sp_h10 = in_mirror ? -10'(in_new_hdg) : 10'(in_new_hdg);
		sp_h   = wrap_hdg($signed({sp_h10, 16'h0000}));
	end

	// fold the old heading into -90..90 for the cordic
	logic signed [25:0] hz;
	logic               fold_init;

	always_comb begin
		hz        = 26'(heading_acc_q);
		fold_init = 1'b0;
		if (heading_acc_q > otwo_pkg::DEG90) begin
			hz        = 26'(heading_acc_q) - H180;
			fold_init = 1'b1;
		end else if (heading_acc_q < -otwo_pkg::DEG90) begin
			hz        = 26'(heading_acc_q) + H180;
			fold_init = 1'b1;
		end
	end

	// one cordic rotation per cycle
	logic signed [33:0] xs, ys, atan_ext, cx_n, cy_n, cz_n;

	always_comb begin
		xs       = cx_q >>> iter_q;
		ys       = cy_q >>> iter_q;
		atan_ext = $signed({2'b00, otwo_pkg::ATAN_TAB[iter_q]});
		if (!cz_q[33]) begin
			cx_n = cx_q - ys;
			cy_n = cy_q + xs;
			cz_n = cz_q - atan_ext;
		end else begin
			cx_n = cx_q + ys;
			cy_n = cy_q - xs;
			cz_n = cz_q + atan_ext;
		end
	end

	// round to q16
	logic signed [33:0] xr, yr;
	assign xr = (fold_neg_q ? -cx_q : cx_q) + 34'sd8192;
	assign yr = (fold_neg_q ? -cy_q : cy_q) + 34'sd8192;

	// sqrt(3) scaling
	logic signed [37:0] r3s_p, r3c_p;
	always_comb begin
		r3s_p = sin_q * SQRT3_Q16;
		r3c_p = cos_q * SQRT3_Q16;
		r3s_p = r3s_p + 38'sd32768;
		r3c_p = r3c_p + 38'sd32768;
	end

	// matrix coefficients
	logic signed [20:0] c21, s21;
	assign c21 = 21'(cos_q);
	assign s21 = 21'(sin_q);

	// matrix sums, one bit of each delta per cycle, msb first
	logic signed [22:0] selx, sely;
	logic signed [53:0] tx_n, ty_n;

	always_comb begin
		selx = 23'(da_sh_q[31] ? kxa_q : 21'sd0) + 23'(db_sh_q[31] ? kxb_q : 21'sd0)
			+ 23'(dc_sh_q[31] ? kxc_q : 21'sd0);
		sely = 23'(da_sh_q[31] ? kya_q : 21'sd0) + 23'(db_sh_q[31] ? kyb_q : 21'sd0)
			+ 23'(dc_sh_q[31] ? kyc_q : 21'sd0);
		if (bit_q == 6'd0) begin
			// sign bit carries negative weight
			tx_n = -54'(selx);
			ty_n = -54'(sely);
		end else begin
			tx_n = (tx_q <<< 1) + 54'(selx);
			ty_n = (ty_q <<< 1) + 54'(sely);
		end
	end

	logic signed [33:0] abs_sd;
	assign abs_sd = sumd_q[33] ? -sumd_q : sumd_q;

	// gain products, one gain bit per cycle, msb first
	logic [85:0] px_n, py_n;
	logic [64:0] ph_n;
	assign px_n = {px_q[84:0], 1'b0} + (lg_sh_q[31] ? {32'h0, magx_q} : 86'h0);
	assign py_n = {py_q[84:0], 1'b0} + (lg_sh_q[31] ? {32'h0, magy_q} : 86'h0);
	assign ph_n = {ph_q[63:0], 1'b0} + (hg_sh_q[31] ? {32'h0, magh_q} : 65'h0);

	// rounding and clamps ahead of the divide, heading update
	logic [62:0]        mx6, my6;
	logic [35:0]        dvx_init, dvy_init;
	logic [65:0]        phr;
	logic [23:0]        qh;
	logic signed [25:0] inc26;
	logic signed [24:0] hd_new;

	always_comb begin
		// (m + 6) / 4, clamped far past the saturation point
		mx6      = {1'b0, px_q[85:24]} + 63'd6;
		my6      = {1'b0, py_q[85:24]} + 63'd6;
		dvx_init = (|mx6[62:38]) ? {36{1'b1}} : mx6[37:2];
		dvy_init = (|my6[62:38]) ? {36{1'b1}} : my6[37:2];
		phr      = {1'b0, ph_q} + 66'h8000;
		qh       = (phr[65:16] > 50'd11796480) ? 24'd11796480 : phr[39:16];
		inc26    = sgnh_q ? $signed({2'b00, qh}) : -$signed({2'b00, qh});
		hd_new   = wrap_hdg(26'(heading_acc_q) + inc26);
	end

	// divide by three, one quotient bit per cycle
	logic [2:0] tdx, tdy;
	logic       gex, gey;
	assign tdx = {remx_q, dvx_q[35]};
	assign tdy = {remy_q, dvy_q[35]};
	assign gex = (tdx >= 3'd3);
	assign gey = (tdy >= 3'd3);

	// final add with saturation
	logic signed [37:0] rx, ry, sx, sy;
	always_comb begin
		rx = $signed({2'b00, dvx_q});
		ry = $signed({2'b00, dvy_q});
		sx = 38'(x_acc_q) + (sgnx_q ? -rx : rx);
		sy = 38'(y_acc_q) + (sgny_q ? -ry : ry);
	end

	logic out_free;
	assign out_free = !out_valid_q || m_axis_tready;

	// sequencer, output register, pose and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			iter_q         <= '0;
			bit_q          <= '0;
			out_valid_q    <= 1'b0;
			out_data_q     <= '0;
			heading_gain_q <= '0;
			linear_gain_q  <= '0;
			field_length_q <= otwo_pkg::FIELD_LENGTH_RST;
			x_acc_q        <= '0;
			y_acc_q        <= '0;
			heading_acc_q  <= '0;
			last_a_q       <= '0;
			last_b_q       <= '0;
			last_c_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					otwo_pkg::CFG_HEADING_GAIN: heading_gain_q <= cfg_data;
					otwo_pkg::CFG_LINEAR_GAIN:  linear_gain_q  <= cfg_data;
					otwo_pkg::CFG_FIELD_LENGTH: field_length_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						last_a_q <= in_cnt_a;
						last_b_q <= in_cnt_b;
						last_c_q <= in_cnt_c;
						iter_q   <= '0;
						state_q  <= s_axis_tuser ? ST_OUT : ST_TRIG;
					end
				end
				ST_TRIG: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_LAST) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: state_q <= ST_ROOT3;
				ST_ROOT3: state_q <= ST_COEF;
				ST_COEF: begin
					bit_q   <= '0;
					state_q <= ST_MAT;
				end
				ST_MAT: begin
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd31) begin
						state_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					bit_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd31) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					bit_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd35) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						x_acc_q       <= nx_q;
						y_acc_q       <= ny_q;
						heading_acc_q <= nh_q;
						out_valid_q   <= 1'b1;
						out_data_q    <= {7'h00, dc_q, db_q, da_q, nh_q, ny_q, nx_q};
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					if (s_axis_tuser) begin
						nx_q <= sp_x;
						ny_q <= {in_new_y, 16'h0000};
						nh_q <= sp_h;
						da_q <= '0;
						db_q <= '0;
						dc_q <= '0;
					end else begin
						// wrapping deltas
						da_q <= in_cnt_a - last_a_q;
						db_q <= in_cnt_b - last_b_q;
						dc_q <= in_cnt_c - last_c_q;
					end
					cx_q       <= CORDIC_X0;
					cy_q       <= '0;
					cz_q       <= $signed({hz, 8'h00});
					fold_neg_q <= fold_init;
				end
			end
			ST_TRIG: begin
				cx_q <= cx_n;
				cy_q <= cy_n;
				cz_q <= cz_n;
			end
			ST_ROUND: begin
				cos_q  <= xr[33:14];
				sin_q  <= yr[33:14];
				sumd_q <= 34'(da_q) + 34'(db_q) + 34'(dc_q);
			end
			ST_ROOT3: begin
				r3s_q <= r3s_p[35:16];
				r3c_q <= r3c_p[35:16];
			end
			ST_COEF: begin
				kxa_q   <= -(c21 <<< 1);
				kxb_q   <= c21 - 21'(r3s_q);
				kxc_q   <= c21 + 21'(r3s_q);
				kya_q   <= -(s21 <<< 1);
				kyb_q   <= s21 + 21'(r3c_q);
				kyc_q   <= s21 - 21'(r3c_q);
				da_sh_q <= da_q;
				db_sh_q <= db_q;
				dc_sh_q <= dc_q;
			end
			ST_MAT: begin
				tx_q    <= tx_n;
				ty_q    <= ty_n;
				da_sh_q <= {da_sh_q[30:0], 1'b0};
				db_sh_q <= {db_sh_q[30:0], 1'b0};
				dc_sh_q <= {dc_sh_q[30:0], 1'b0};
			end
			ST_ABS: begin
				sgnx_q  <= tx_q[53];
				sgny_q  <= ty_q[53];
				sgnh_q  <= sumd_q[33];
				magx_q  <= tx_q[53] ? $unsigned(-tx_q) : $unsigned(tx_q);
				magy_q  <= ty_q[53] ? $unsigned(-ty_q) : $unsigned(ty_q);
				magh_q  <= abs_sd[32:0];
				lg_sh_q <= linear_gain_q;
				hg_sh_q <= heading_gain_q;
				px_q    <= '0;
				py_q    <= '0;
				ph_q    <= '0;
			end
			ST_MUL: begin
				px_q    <= px_n;
				py_q    <= py_n;
				ph_q    <= ph_n;
				lg_sh_q <= {lg_sh_q[30:0], 1'b0};
				hg_sh_q <= {hg_sh_q[30:0], 1'b0};
			end
			ST_PREP: begin
				dvx_q  <= dvx_init;
				dvy_q  <= dvy_init;
				remx_q <= '0;
				remy_q <= '0;
				nh_q   <= hd_new;
			end
			ST_DIV: begin
				remx_q <= gex ? 2'(tdx - 3'd3) : tdx[1:0];
				remy_q <= gey ? 2'(tdy - 3'd3) : tdy[1:0];
				dvx_q  <= {dvx_q[34:0], gex};
				dvy_q  <= {dvy_q[34:0], gey};
			end
			ST_SUM: begin
				nx_q <= sat32(sx);
				ny_q <= sat32(sy);
			end
			default: ;
		endcase
	end

endmodule

// ----- design/otwo_checker.sv -----
// port-level checks of the omni odometry block and their binding
module otwo_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [otwo_pkg::OUT_W-1:0] m_axis_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// one item at a time: busy right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while busy");

	// a new result only comes out of the busy sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without work");

	// heading always wrapped into -180..180
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[88:64]) <= otwo_pkg::DEG180)
			&& ($signed(m_axis_tdata[88:64]) >= -otwo_pkg::DEG180))
		else $error("heading out of range");

endmodule

bind omni_three_wheel_odometry otwo_checker u_otwo_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
